/* sv/pdf_string_token_decoder_assert.svh */
// assertion macros shared by the checker
`ifndef PDF_STRING_TOKEN_DECODER_ASSERT_SVH
`define PDF_STRING_TOKEN_DECODER_ASSERT_SVH

`define PSTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define PSTD_ASSERT_IMP(label, ante, cons, msg) \
    `PSTD_ASSERT(label, (ante) |-> (cons), msg)

`define PSTD_ASSERT_NEXT(label, ante, cons, msg) \
    `PSTD_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* sv/pstd_pkg.sv */
package pstd_pkg;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_NOSTR = 2'd2;
    localparam logic [1:0] KIND_LONG  = 2'd3;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  kind;
        logic [15:0] string_length;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

endpackage

/* sv/pstd_front.sv */
module pstd_front
    import pstd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_char_in,
    input  logic [15:0] i_max_source_length,
    input  logic        i_full,
    output logic        o_stall,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LIT  = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;

    localparam logic [7:0] DEPTH_LIMIT = 8'd255;

    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_T    = 8'h74;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    logic [1:0]  r_mode, n_mode;
    logic [7:0]  r_nest, n_nest;
    logic        r_esc, n_esc;
    logic [1:0]  r_od, n_od;
    logic [7:0]  r_ov, n_ov;
    logic        r_hp, n_hp;
    logic [3:0]  r_hn, n_hn;
    logic [15:0] r_sc, n_sc;
    logic [15:0] r_dc, n_dc;

    logic        w_accept;
    logic        w_dig;
    logic [7:0]  w_d;
    logic [7:0]  w_ov_acc;
    logic [4:0]  w_hex;
    logic [16:0] w_cnt_src;
    logic        w_closing;
    t_result     w_res [2];
    logic [1:0]  w_n;

    assign w_accept  = i_valid && !i_full;
    assign o_stall   = i_full;
    assign w_dig     = (i_char_in inside {[8'h30:8'h39]});
    assign w_d       = i_char_in - CH_ZERO;
    assign w_ov_acc  = {r_ov[4:0], 3'b000} + w_d;
    assign w_hex     = hex_val(i_char_in);
    assign w_cnt_src = {1'b0, r_sc} + 17'd1;

    always_comb begin
        logic done;
        done      = 1'b0;
        w_closing = 1'b0;
        n_mode = r_mode;
        n_nest = r_nest;
        n_esc  = r_esc;
        n_od   = r_od;
        n_ov   = r_ov;
        n_hp   = r_hp;
        n_hn   = r_hn;
        n_sc   = r_sc;
        n_dc   = r_dc;
        w_n    = 2'd0;
        w_res[0] = '0;
        w_res[1] = '0;
        if (w_accept) begin
            if (r_mode == MODE_LIT || r_mode == MODE_HEX) begin
                if (r_mode == MODE_LIT) begin
                    w_closing = (i_char_in == CH_RPAR) && (r_nest == 8'd0)
                             && (!r_esc || r_od != 2'd0);
                end else begin
                    w_closing = (i_char_in == CH_GT);
                end
                if (!w_closing) begin
                    if (w_cnt_src >= {1'b0, i_max_source_length}) begin
                        w_res[w_n[0]] = '{out_byte: 8'd0, kind: KIND_LONG,
                                          string_length: 16'd0};
                        w_n = w_n + 2'd1;
                        done = 1'b1;
                        n_mode = MODE_IDLE; n_nest = '0; n_esc = 1'b0; n_od = '0;
                        n_ov = '0; n_hp = 1'b0; n_hn = '0; n_sc = '0; n_dc = '0;
                    end else begin
                        n_sc = w_cnt_src[15:0];
                    end
                end
                if (!done && r_mode == MODE_LIT) begin
                    // pending octal escape
                    if (r_od != 2'd0) begin
                        if (w_dig) begin
                            if (r_od == 2'd2) begin
                                w_res[w_n[0]] = '{out_byte: w_ov_acc, kind: KIND_DATA,
                                                  string_length: 16'd0};
                                w_n  = w_n + 2'd1;
                                n_dc = n_dc + 16'd1;
                                n_od = 2'd0;
                                n_ov = 8'd0;
                            end else begin
                                n_od = r_od + 2'd1;
                                n_ov = w_ov_acc;
                            end
                            done = 1'b1;
                        end else begin
                            w_res[w_n[0]] = '{out_byte: r_ov, kind: KIND_DATA,
                                              string_length: 16'd0};
                            w_n  = w_n + 2'd1;
                            n_dc = n_dc + 16'd1;
                            n_od = 2'd0;
                            n_ov = 8'd0;
                        end
                    end
                    if (!done) begin
                        if (r_esc) begin
                            n_esc = 1'b0;
                            if (w_dig) begin
                                n_od = 2'd1;
                                n_ov = w_d;
                            end else begin
                                case (i_char_in)
                                    CH_B, CH_F, CH_N, CH_R, CH_T,
                                    CH_LPAR, CH_RPAR, CH_BSL: begin
                                        w_res[w_n[0]].kind          = KIND_DATA;
                                        w_res[w_n[0]].string_length = 16'd0;
                                        case (i_char_in)
                                            CH_B:    w_res[w_n[0]].out_byte = 8'h08;
                                            CH_F:    w_res[w_n[0]].out_byte = 8'h0C;
                                            CH_N:    w_res[w_n[0]].out_byte = 8'h0A;
                                            CH_R:    w_res[w_n[0]].out_byte = 8'h0D;
                                            CH_T:    w_res[w_n[0]].out_byte = 8'h09;
                                            default: w_res[w_n[0]].out_byte = i_char_in;
                                        endcase
                                        w_n  = w_n + 2'd1;
                                        n_dc = n_dc + 16'd1;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end else if (i_char_in == CH_BSL) begin
                            n_esc = 1'b1;
                        end else if (i_char_in == CH_LPAR && r_nest >= DEPTH_LIMIT) begin
                            w_res[w_n[0]] = '{out_byte: 8'd0, kind: KIND_LONG,
                                              string_length: 16'd0};
                            w_n = w_n + 2'd1;
                            n_mode = MODE_IDLE; n_nest = '0; n_esc = 1'b0; n_od = '0;
                            n_ov = '0; n_hp = 1'b0; n_hn = '0; n_sc = '0; n_dc = '0;
                        end else if (i_char_in == CH_RPAR && r_nest == 8'd0) begin
                            w_res[w_n[0]] = '{out_byte: 8'd0, kind: KIND_END,
                                              string_length: n_dc};
                            w_n = w_n + 2'd1;
                            n_mode = MODE_IDLE; n_nest = '0; n_esc = 1'b0; n_od = '0;
                            n_ov = '0; n_hp = 1'b0; n_hn = '0; n_sc = '0; n_dc = '0;
                        end else begin
                            if (i_char_in == CH_LPAR) begin
                                n_nest = r_nest + 8'd1;
                            end else if (i_char_in == CH_RPAR) begin
                                n_nest = r_nest - 8'd1;
                            end
                            w_res[w_n[0]] = '{out_byte: i_char_in, kind: KIND_DATA,
                                              string_length: 16'd0};
                            w_n  = w_n + 2'd1;
                            n_dc = n_dc + 16'd1;
                        end
                    end
                end else if (!done) begin
                    // hex string
                    if (w_closing) begin
                        if (r_hp) begin
                            w_res[w_n[0]] = '{out_byte: {r_hn, 4'h0}, kind: KIND_DATA,
                                              string_length: 16'd0};
                            w_n  = w_n + 2'd1;
                            n_dc = n_dc + 16'd1;
                        end
                        w_res[w_n[0]] = '{out_byte: 8'd0, kind: KIND_END,
                                          string_length: n_dc};
                        w_n = w_n + 2'd1;
                        n_mode = MODE_IDLE; n_nest = '0; n_esc = 1'b0; n_od = '0;
                        n_ov = '0; n_hp = 1'b0; n_hn = '0; n_sc = '0; n_dc = '0;
                    end else if (w_hex[4]) begin
                        if (!r_hp) begin
                            n_hn = w_hex[3:0];
                            n_hp = 1'b1;
                        end else begin
                            w_res[w_n[0]] = '{out_byte: {r_hn, w_hex[3:0]}, kind: KIND_DATA,
                                              string_length: 16'd0};
                            w_n  = w_n + 2'd1;
                            n_dc = n_dc + 16'd1;
                            n_hp = 1'b0;
                            n_hn = 4'h0;
                        end
                    end
                end
            end else begin
                n_mode = MODE_IDLE; n_nest = '0; n_esc = 1'b0; n_od = '0;
                n_ov = '0; n_hp = 1'b0; n_hn = '0; n_sc = '0; n_dc = '0;
                if (i_char_in == CH_LPAR) begin
                    n_mode = MODE_LIT;
                end else if (i_char_in == CH_LT) begin
                    n_mode = MODE_HEX;
                end else begin
                    w_res[w_n[0]] = '{out_byte: 8'd0, kind: KIND_NOSTR,
                                      string_length: 16'd0};
                    w_n = w_n + 2'd1;
                end
            end
        end
    end

    assign o_push        = w_accept && (w_n != 2'd0);
    assign o_entry.two   = (w_n == 2'd2);
    assign o_entry.r0    = w_res[0];
    assign o_entry.r1    = w_res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_nest <= '0;
            r_esc  <= 1'b0;
            r_od   <= '0;
            r_ov   <= '0;
            r_hp   <= 1'b0;
            r_hn   <= '0;
            r_sc   <= '0;
            r_dc   <= '0;
        end else begin
            r_mode <= n_mode;
            r_nest <= n_nest;
            r_esc  <= n_esc;
            r_od   <= n_od;
            r_ov   <= n_ov;
            r_hp   <= n_hp;
            r_hn   <= n_hn;
            r_sc   <= n_sc;
            r_dc   <= n_dc;
        end
    end

endmodule

/* sv/pstd_queue.sv */
module pstd_queue
    import pstd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_nempty,
    output t_entry o_head
);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, n_wr;
    logic [QUEUE_AW-1:0]   r_rd, n_rd;
    logic [QUEUE_AW:0]     r_count, n_count;

    assign o_full   = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_head   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + QUEUE_AW'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + QUEUE_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

/* sv/pstd_back.sv */
module pstd_back
    import pstd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nempty,
    input  t_entry      i_head,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_kind,
    output logic [15:0] o_string_length,
    output logic        o_last
);

    logic    r_valid;
    logic    r_sec;
    t_entry  r_ent;
    logic    w_take;
    logic    w_fin;
    t_result w_res;

    assign w_take = r_valid && !i_stall;
    assign w_fin  = w_take && (!r_ent.two || r_sec);
    assign o_pop  = (!r_valid || w_fin) && i_nempty;

    assign w_res           = r_sec ? r_ent.r1 : r_ent.r0;
    assign o_valid         = r_valid;
    assign o_out_byte      = w_res.out_byte;
    assign o_kind          = w_res.kind;
    assign o_string_length = w_res.string_length;
    assign o_last          = !r_ent.two || r_sec;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sec   <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_sec   <= 1'b0;
        end else if (w_fin) begin
            r_valid <= 1'b0;
            r_sec   <= 1'b0;
        end else if (w_take) begin
            r_sec   <= 1'b1;
        end
    end

endmodule

/* sv/pdf_string_token_decoder.sv */
// PDF string token decoder. Takes one source character per request on i_char_in and
// returns decoded results: data bytes, string end with the decoded length, not a
// string start, or too long. A character is accepted every cycle while o_stall is
// low; a character that yields two results (an octal byte closed by a non-digit, a
// padded hex nibble before the end) is queued as one entry and presented as two
// results in turn on the output side. A four-entry result queue sits between the
// decoder and the output register, and o_stall rises only when it is full.
// max_source_length is at byte address 0 of the APB port and should be written only
// while no token is open.
module pdf_string_token_decoder
    import pstd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_kind,
    output logic [15:0] o_string_length,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_max_source_length;
    logic        w_full;
    logic        w_nempty;
    logic        w_push;
    logic        w_pop;
    t_entry      w_entry;
    t_entry      w_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_max_source_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_source_length <= 16'hFFFF;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_max_source_length <= pwdata[15:0];
        end
    end

    pstd_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .i_char_in           (i_char_in),
        .i_max_source_length (r_max_source_length),
        .i_full              (w_full),
        .o_stall             (o_stall),
        .o_push              (w_push),
        .o_entry             (w_entry)
    );

    pstd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_nempty (w_nempty),
        .o_head   (w_head)
    );

    pstd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nempty        (w_nempty),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_kind          (o_kind),
        .o_string_length (o_string_length),
        .o_last          (o_last)
    );

endmodule

/* sv/pstd_checker.sv */
`include "pdf_string_token_decoder_assert.svh"

module pstd_checker
    import pstd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic [1:0]  o_kind,
    input logic [15:0] o_string_length,
    input logic        o_last
);

    `PSTD_ASSERT_NEXT(a_valid_held, o_valid && i_stall, o_valid, "result dropped while stalled")
    `PSTD_ASSERT_IMP(a_byte_zero, o_valid && o_kind != KIND_DATA, o_out_byte == 8'd0, "byte set on status")
    `PSTD_ASSERT_IMP(a_len_zero, o_valid && o_kind != KIND_END, o_string_length == 16'd0, "length set")
    `PSTD_ASSERT_IMP(a_status_last, o_valid && o_kind != KIND_DATA, o_last, "status result not last")
    `PSTD_ASSERT_NEXT(a_pair_follows, o_valid && !o_last && !i_stall, o_valid, "second result missing")

endmodule

bind pdf_string_token_decoder pstd_checker u_pstd_checker (.*);
